### hdl/quaternion_rotate_vector_defines.svh
// assertion macros for the quaternion rotation block
// expects clk and arst_n in the scope of use
`ifndef QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QRV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrv same-cycle check failed");

// next-cycle implication, checked outside reset
`define QRV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrv next-cycle check failed");

`endif

### hdl/qrv_pkg.sv
// shared widths, request types and rounding helpers for the quaternion rotation block
// no dependencies
`timescale 1ns / 1ps

package qrv_pkg;

	localparam int DATA_WIDTH     = 32;
	localparam int QUAT_FRAC_BITS = 30;
	localparam int GUARD_BITS     = 4;
	localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;
	localparam int MID_WIDTH      = DATA_WIDTH + GUARD_BITS;

	// first pass: q times v, three products per component
	localparam int P1_WIDTH  = QUAT_WIDTH + DATA_WIDTH;
	localparam int S1_WIDTH  = P1_WIDTH + 2;
	localparam int S1_SHIFTW = S1_WIDTH - QUAT_FRAC_BITS;
	localparam int S1_TOP    = S1_SHIFTW - MID_WIDTH + 1;

	// second pass: t times conj(q), four products per component
	localparam int P2_WIDTH  = MID_WIDTH + QUAT_WIDTH;
	localparam int S2_WIDTH  = P2_WIDTH + 2;
	localparam int S2_SHIFTW = S2_WIDTH - QUAT_FRAC_BITS;
	localparam int S2_TOP    = S2_SHIFTW - DATA_WIDTH + 1;

	typedef struct packed {
		logic signed [QUAT_WIDTH-1:0] quat_w;
		logic signed [QUAT_WIDTH-1:0] quat_x;
		logic signed [QUAT_WIDTH-1:0] quat_y;
		logic signed [QUAT_WIDTH-1:0] quat_z;
		logic signed [DATA_WIDTH-1:0] vec_x;
		logic signed [DATA_WIDTH-1:0] vec_y;
		logic signed [DATA_WIDTH-1:0] vec_z;
	} in_req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] rot_x;
		logic signed [DATA_WIDTH-1:0] rot_y;
		logic signed [DATA_WIDTH-1:0] rot_z;
		logic                         overflow;
	} out_req_t;

	typedef struct packed {
		logic                        ovf;
		logic signed [MID_WIDTH-1:0] val;
	} mid_rs_t;

	typedef struct packed {
		logic                         ovf;
		logic signed [DATA_WIDTH-1:0] val;
	} out_rs_t;

	// round half up at the q shift, saturate to the guarded width
	function automatic mid_rs_t round_mid(input logic signed [S1_WIDTH-1:0] a);
		logic signed [S1_WIDTH-1:0]  r;
		logic signed [S1_SHIFTW-1:0] s;
		logic        [S1_TOP-1:0]    top;
		mid_rs_t                     o;
		r   = a + $signed(S1_WIDTH'(1) << (QUAT_FRAC_BITS - 1));
		s   = r[S1_WIDTH-1:QUAT_FRAC_BITS];
		top = s[S1_SHIFTW-1:MID_WIDTH-1];
		if ((&top) || !(|top)) begin
			o.ovf = 1'b0;
			o.val = s[MID_WIDTH-1:0];
		end else begin
			o.ovf = 1'b1;
			o.val = {s[S1_SHIFTW-1], {(MID_WIDTH-1){~s[S1_SHIFTW-1]}}};
		end
		return o;
	endfunction

	// round half up at the q shift, saturate to the output width
	function automatic out_rs_t round_out(input logic signed [S2_WIDTH-1:0] a);
		logic signed [S2_WIDTH-1:0]  r;
		logic signed [S2_SHIFTW-1:0] s;
		logic        [S2_TOP-1:0]    top;
		out_rs_t                     o;
		r   = a + $signed(S2_WIDTH'(1) << (QUAT_FRAC_BITS - 1));
		s   = r[S2_WIDTH-1:QUAT_FRAC_BITS];
		top = s[S2_SHIFTW-1:DATA_WIDTH-1];
		if ((&top) || !(|top)) begin
			o.ovf = 1'b0;
			o.val = s[DATA_WIDTH-1:0];
		end else begin
			o.ovf = 1'b1;
			o.val = {s[S2_SHIFTW-1], {(DATA_WIDTH-1){~s[S2_SHIFTW-1]}}};
		end
		return o;
	endfunction

endpackage

### hdl/quaternion_rotate_vector.sv
// Rotates a 3-vector by an unnormalised Q2.30 quaternion as the vector part of q*v*conj(q);
// a non-unit q scales the result by its squared norm, and the output saturates with a flag.
// A request is taken every clock while in_stall is low and passes the stages in order:
// stage one forms the twelve q*v products, stage two sums, rounds and keeps four guard bits,
// stage three forms the twelve t*conj(q) products, stage four sums, rounds and saturates. A
// stall on the output fills empty stages first and then holds the input. Depends on qrv_pkg
// and the defines header.
`timescale 1ns / 1ps

module quaternion_rotate_vector
	import qrv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output out_req_t out_data
);

	`include "quaternion_rotate_vector_defines.svh"

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// stage one: products and quaternion copy
	logic signed [P1_WIDTH-1:0] q1vx_s1, q2vy_s1, q3vz_s1;
	logic signed [P1_WIDTH-1:0] q0vx_s1, q2vz_s1, q3vy_s1;
	logic signed [P1_WIDTH-1:0] q0vy_s1, q3vx_s1, q1vz_s1;
	logic signed [P1_WIDTH-1:0] q0vz_s1, q1vy_s1, q2vx_s1;
	logic signed [QUAT_WIDTH-1:0] qw_s1, qx_s1, qy_s1, qz_s1;

	// stage two: guarded intermediate
	logic signed [MID_WIDTH-1:0] t0_s2, t1_s2, t2_s2, t3_s2;
	logic signed [QUAT_WIDTH-1:0] qw_s2, qx_s2, qy_s2, qz_s2;
	logic ovf_s2;

	// stage three: second products
	logic signed [P2_WIDTH-1:0] t0q1_s3, t1q0_s3, t2q3_s3, t3q2_s3;
	logic signed [P2_WIDTH-1:0] t0q2_s3, t2q0_s3, t3q1_s3, t1q3_s3;
	logic signed [P2_WIDTH-1:0] t0q3_s3, t3q0_s3, t1q2_s3, t2q1_s3;
	logic ovf_s3;

	out_req_t out_s4;

	logic signed [S1_WIDTH-1:0] a0, a1, a2, a3;
	mid_rs_t m0, m1, m2, m3;
	logic signed [S2_WIDTH-1:0] b0, b1, b2;
	out_rs_t r0, r1, r2;

	// bubble-collapsing advance chain
	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	assign out_valid = v_s4;
	assign out_data  = out_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			q1vx_s1 <= in_data.quat_x * in_data.vec_x;
			q2vy_s1 <= in_data.quat_y * in_data.vec_y;
			q3vz_s1 <= in_data.quat_z * in_data.vec_z;
			q0vx_s1 <= in_data.quat_w * in_data.vec_x;
			q2vz_s1 <= in_data.quat_y * in_data.vec_z;
			q3vy_s1 <= in_data.quat_z * in_data.vec_y;
			q0vy_s1 <= in_data.quat_w * in_data.vec_y;
			q3vx_s1 <= in_data.quat_z * in_data.vec_x;
			q1vz_s1 <= in_data.quat_x * in_data.vec_z;
			q0vz_s1 <= in_data.quat_w * in_data.vec_z;
			q1vy_s1 <= in_data.quat_x * in_data.vec_y;
			q2vx_s1 <= in_data.quat_y * in_data.vec_x;
			qw_s1   <= in_data.quat_w;
			qx_s1   <= in_data.quat_x;
			qy_s1   <= in_data.quat_y;
			qz_s1   <= in_data.quat_z;
		end
	end

	always_comb begin
		a0 = -(S1_WIDTH'(q1vx_s1) + S1_WIDTH'(q2vy_s1) + S1_WIDTH'(q3vz_s1));
		a1 = S1_WIDTH'(q0vx_s1) + S1_WIDTH'(q2vz_s1) - S1_WIDTH'(q3vy_s1);
		a2 = S1_WIDTH'(q0vy_s1) + S1_WIDTH'(q3vx_s1) - S1_WIDTH'(q1vz_s1);
		a3 = S1_WIDTH'(q0vz_s1) + S1_WIDTH'(q1vy_s1) - S1_WIDTH'(q2vx_s1);
		m0 = round_mid(a0);
		m1 = round_mid(a1);
		m2 = round_mid(a2);
		m3 = round_mid(a3);
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			t0_s2  <= m0.val;
			t1_s2  <= m1.val;
			t2_s2  <= m2.val;
			t3_s2  <= m3.val;
			ovf_s2 <= m0.ovf | m1.ovf | m2.ovf | m3.ovf;
			qw_s2  <= qw_s1;
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			qz_s2  <= qz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			t0q1_s3 <= t0_s2 * qx_s2;
			t1q0_s3 <= t1_s2 * qw_s2;
			t2q3_s3 <= t2_s2 * qz_s2;
			t3q2_s3 <= t3_s2 * qy_s2;
			t0q2_s3 <= t0_s2 * qy_s2;
			t2q0_s3 <= t2_s2 * qw_s2;
			t3q1_s3 <= t3_s2 * qx_s2;
			t1q3_s3 <= t1_s2 * qz_s2;
			t0q3_s3 <= t0_s2 * qz_s2;
			t3q0_s3 <= t3_s2 * qw_s2;
			t1q2_s3 <= t1_s2 * qy_s2;
			t2q1_s3 <= t2_s2 * qx_s2;
			ovf_s3  <= ovf_s2;
		end
	end

	always_comb begin
		b0 = S2_WIDTH'(t1q0_s3) - S2_WIDTH'(t0q1_s3)
			- S2_WIDTH'(t2q3_s3) + S2_WIDTH'(t3q2_s3);
		b1 = S2_WIDTH'(t2q0_s3) - S2_WIDTH'(t0q2_s3)
			- S2_WIDTH'(t3q1_s3) + S2_WIDTH'(t1q3_s3);
		b2 = S2_WIDTH'(t3q0_s3) - S2_WIDTH'(t0q3_s3)
			- S2_WIDTH'(t1q2_s3) + S2_WIDTH'(t2q1_s3);
		r0 = round_out(b0);
		r1 = round_out(b1);
		r2 = round_out(b2);
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			out_s4.rot_x    <= r0.val;
			out_s4.rot_y    <= r1.val;
			out_s4.rot_z    <= r2.val;
			out_s4.overflow <= ovf_s3 | r0.ovf | r1.ovf | r2.ovf;
		end
	end

	// checks
	`QRV_ASSERT_NOW(a_stall_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4 && out_stall)
	`QRV_ASSERT_NEXT(a_enter_s1, in_valid && !in_stall, v_s1)
	`QRV_ASSERT_NEXT(a_reach_out, v_s3 && en4, out_valid)

endmodule
